[rtl/iccc_pkg.sv]
// Package for the IPv4 ICMP checksum checker: beat types, status codes,
// constants and the ones' complement add. No dependencies.
package iccc_pkg;

    // Fewest ICMP bytes a datagram must carry beyond its IP header.
    localparam int unsigned MIN_ICMP_BYTES = 8;

    // Smallest legal IP header in bytes (IHL of five).
    localparam logic [5:0] MIN_HDR_BYTES = 6'd20;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_SHORT     = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_LEN_ERROR = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [5:0]  header_length;
        logic [15:0] icmp_length;
        logic [15:0] computed_checksum;
        logic [15:0] received_checksum;
    } t_out_beat;

    // Ones' complement add of two 16-bit words with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        end
    endfunction

endpackage

[rtl/ipv4_icmp_checksum_checker_top.sv]
// IPv4 ICMP checksum checker, top level.
// Depends on iccc_pkg for beat types, status codes and the ones' complement add.
//
// Result path: the final input beat is held in the input register and, once the
//   result register is free, moves into it; the result beat is offered from there.
// Throughput: one input beat per cycle, sustained, set by the combinational
//   add and fold on the running sum; a final byte held by a full result
//   register stalls the input until that register frees.
// Reset: i_rst_n is synchronous and active low; it empties both registers
//   and clears the per-datagram state (byte count, lengths, sum, checksum).
module ipv4_icmp_checksum_checker_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  iccc_pkg::t_in_beat  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output iccc_pkg::t_out_beat o_out_data
);

    // Input register: holds one accepted byte until it is folded into the state.
    logic               r_in_valid;
    iccc_pkg::t_in_beat r_in;

    // Result register.
    logic                r_out_valid;
    iccc_pkg::t_out_beat r_out;
    iccc_pkg::t_out_beat n_out;

    // Per-datagram state.
    logic [15:0] r_byte_count, n_byte_count;
    logic [5:0]  r_ihl, n_ihl;
    logic [15:0] r_total_len, n_total_len;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_hold, n_hold;
    logic        r_odd, n_odd;
    logic [15:0] r_saved_csum, n_saved_csum;

    logic        out_free;
    logic        in_go;
    logic        in_take;
    logic [15:0] idx;
    logic [7:0]  data;
    logic [15:0] csum_hi_idx;
    logic [15:0] csum_lo_idx;
    logic        in_region;
    logic [7:0]  word_byte;
    logic [15:0] final_sum;
    logic [15:0] computed;
    logic [16:0] received;
    logic [16:0] short_limit;

    // The result register can take a new beat when empty or when its beat leaves now.
    assign out_free = !r_out_valid || !i_out_stall;

    // A held byte moves on unless it ends a datagram and the result register is full.
    assign in_go   = r_in_valid && (!r_in.last_byte || out_free);
    assign in_take = i_in_valid && !o_in_stall;

    assign o_in_stall  = r_in_valid && !in_go;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign idx  = r_byte_count;
    assign data = r_in.data_byte;

    always_comb begin
        // Header fields; the length captured on this byte is already in effect.
        n_ihl       = (idx == 16'd0) ? {data[3:0], 2'b00} : r_ihl;
        n_total_len = r_total_len;
        if (idx == 16'd2) begin
            n_total_len = {data, r_total_len[7:0]};
        end
        if (idx == 16'd3) begin
            n_total_len = {r_total_len[15:8], data};
        end

        // The ICMP checksum field sits at the third and fourth byte past the header.
        csum_hi_idx  = {10'd0, n_ihl} + 16'd2;
        csum_lo_idx  = {10'd0, n_ihl} + 16'd3;
        n_saved_csum = r_saved_csum;
        if (idx == csum_hi_idx) begin
            n_saved_csum = {data, r_saved_csum[7:0]};
        end
        if (idx == csum_lo_idx) begin
            n_saved_csum = {r_saved_csum[15:8], data};
        end

        // Sum the ICMP region as big-endian words, checksum field as zero.
        in_region = (n_ihl >= iccc_pkg::MIN_HDR_BYTES) && (idx >= {10'd0, n_ihl})
                    && (idx < n_total_len);
        word_byte = (idx == csum_hi_idx || idx == csum_lo_idx) ? 8'd0 : data;
        n_sum  = r_sum;
        n_hold = r_hold;
        n_odd  = r_odd;
        if (in_region) begin
            if (!r_odd) begin
                n_hold = word_byte;
                n_odd  = 1'b1;
            end else begin
                n_sum = iccc_pkg::oc_add(r_sum, {r_hold, word_byte});
                n_odd = 1'b0;
            end
        end

        n_byte_count = (r_byte_count != 16'hffff) ? r_byte_count + 16'd1 : r_byte_count;

        // Closing the datagram: pad an odd trailing byte with a zero low byte.
        final_sum   = n_odd ? iccc_pkg::oc_add(n_sum, {n_hold, 8'd0}) : n_sum;
        computed    = ~final_sum;
        received    = {1'b0, idx} + 17'd1;
        short_limit = {11'd0, n_ihl} + 17'(iccc_pkg::MIN_ICMP_BYTES);

        n_out.header_length     = n_ihl;
        n_out.icmp_length       = (n_total_len >= {10'd0, n_ihl})
                                  ? n_total_len - {10'd0, n_ihl} : 16'd0;
        n_out.computed_checksum = computed;
        n_out.received_checksum = n_saved_csum;
        if (received < short_limit) begin
            n_out.status = iccc_pkg::ST_SHORT;
        end else if (n_ihl < iccc_pkg::MIN_HDR_BYTES || n_total_len < {10'd0, n_ihl}
                     || {1'b0, n_total_len} > received) begin
            n_out.status = iccc_pkg::ST_LEN_ERROR;
        end else if (computed != n_saved_csum) begin
            n_out.status = iccc_pkg::ST_MISMATCH;
        end else begin
            n_out.status = iccc_pkg::ST_VALID;
        end
    end

    // Input register and handshake state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_go) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Datagram state: advances on every processed beat, clears after the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 16'd0;
            r_ihl        <= 6'd0;
            r_total_len  <= 16'd0;
            r_sum        <= 16'd0;
            r_hold       <= 8'd0;
            r_odd        <= 1'b0;
            r_saved_csum <= 16'd0;
        end else if (in_go) begin
            if (r_in.last_byte) begin
                r_byte_count <= 16'd0;
                r_ihl        <= 6'd0;
                r_total_len  <= 16'd0;
                r_sum        <= 16'd0;
                r_hold       <= 8'd0;
                r_odd        <= 1'b0;
                r_saved_csum <= 16'd0;
            end else begin
                r_byte_count <= n_byte_count;
                r_ihl        <= n_ihl;
                r_total_len  <= n_total_len;
                r_sum        <= n_sum;
                r_hold       <= n_hold;
                r_odd        <= n_odd;
                r_saved_csum <= n_saved_csum;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_go && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (in_go && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

endmodule
